/* sv/d1s_pkg.sv */
`default_nettype none

package d1s_pkg;

    localparam int MAX_ROW_DEF = 1024;
    localparam int IDX_W       = 16;
    localparam int QDEPTH      = 4;
    localparam int PADDR_W     = 5;

    localparam logic [2:0] REG_ROW_WIDTH = 3'd0;
    localparam logic [2:0] REG_STRIDE    = 3'd1;
    localparam logic [2:0] REG_PADDING   = 3'd2;
    localparam logic [2:0] REG_DILATION  = 3'd3;
    localparam logic [2:0] REG_MODULATED = 3'd4;

    localparam logic [10:0] ROW_WIDTH_RST = 11'd1024;
    localparam logic [4:0]  STRIDE_RST    = 5'd1;
    localparam logic [7:0]  PADDING_RST   = 8'd0;
    localparam logic [4:0]  DILATION_RST  = 5'd1;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic [10:0] row_width;
        logic [4:0]  stride;
        logic [7:0]  padding;
        logic [4:0]  dilation;
        logic        modulated;
    } t_cfg;

    // one classified item between front and back
    typedef struct packed {
        logic             is_load;
        logic             in_range;
        logic             lv;
        logic             rv;
        logic [IDX_W-1:0] idx_lo;
        logic [IDX_W-1:0] idx_hi;
        logic [7:0]       frac;
        logic [15:0]      data;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

/* sv/d1s_queue.sv */
`default_nettype none

module d1s_queue #(
    parameter int W     = d1s_pkg::ENTRY_W,
    parameter int DEPTH = d1s_pkg::QDEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_wdata,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_rdata,
    output logic              o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

/* sv/d1s_front.sv */
`default_nettype none

module d1s_front #(
    parameter int MAX_ROW = d1s_pkg::MAX_ROW_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire d1s_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_action,
    input  wire logic [9:0]    i_load_index,
    input  wire logic [15:0]   i_load_value,
    input  wire logic [9:0]    i_out_pos,
    input  wire logic [3:0]    i_tap,
    input  wire logic [17:0]   i_offset,
    input  wire logic [15:0]   i_weight,
    output logic               o_push,
    output d1s_pkg::t_entry    o_entry,
    input  wire logic          i_full
);

    logic        r_valid;
    logic        r_is_load;
    logic [9:0]  r_lidx;
    logic [15:0] r_lval;
    logic [14:0] r_pos_prod;
    logic [8:0]  r_tap_prod;
    logic [17:0] r_offset;
    logic [15:0] r_mask;

    logic [14:0]        pos_prod;
    logic [8:0]         tap_prod;
    logic [10:0]        w_eff;
    logic signed [16:0] base;
    logic signed [25:0] xq;
    logic signed [25:0] t;
    logic [10:0]        hi;
    logic               in_rng;
    logic               drop;
    logic               fwd;

    assign pos_prod = i_out_pos * i_cfg.stride;
    assign tap_prod = i_tap * i_cfg.dilation;

    assign drop    = r_is_load && (32'(r_lidx) >= MAX_ROW);
    assign fwd     = r_valid && (!i_full || drop);
    assign o_ready = !r_valid || fwd;
    assign o_push  = r_valid && !i_full && !drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_is_load  <= (i_action == d1s_pkg::ACT_LOAD);
            r_lidx     <= i_load_index;
            r_lval     <= i_load_value;
            r_pos_prod <= pos_prod;
            r_tap_prod <= tap_prod;
            r_offset   <= i_offset;
            r_mask     <= i_weight;
        end
    end

    // position in 1/256 sample units, range check against the clamped width
    always_comb begin
        if (32'(i_cfg.row_width) > MAX_ROW) begin
            w_eff = 11'(MAX_ROW);
        end else begin
            w_eff = i_cfg.row_width;
        end
        base   = $signed({2'b00, r_pos_prod}) - $signed({9'd0, i_cfg.padding})
               + $signed({8'd0, r_tap_prod});
        xq     = $signed({base[16], base, 8'd0})
               + $signed({{8{r_offset[17]}}, r_offset});
        t      = xq + 26'sd256;
        in_rng = (xq > -26'sd256) && (xq < $signed({7'd0, w_eff, 8'd0}));
        hi     = t[18:8];
    end

    always_comb begin
        o_entry = '0;
        if (r_is_load) begin
            o_entry.is_load = 1'b1;
            o_entry.idx_lo  = d1s_pkg::IDX_W'(r_lidx);
            o_entry.data    = r_lval;
        end else begin
            o_entry.is_load  = 1'b0;
            o_entry.in_range = in_rng;
            o_entry.lv       = in_rng && (hi != 11'd0);
            o_entry.rv       = in_rng && (hi < w_eff);
            o_entry.idx_hi   = d1s_pkg::IDX_W'(hi);
            o_entry.idx_lo   = d1s_pkg::IDX_W'(hi) - 1'b1;
            o_entry.frac     = t[7:0];
            o_entry.data     = r_mask;
        end
    end

endmodule

`default_nettype wire

/* sv/d1s_back.sv */
`default_nettype none

module d1s_back #(
    parameter int MAX_ROW = d1s_pkg::MAX_ROW_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_modulated,
    input  wire d1s_pkg::t_entry i_entry,
    input  wire logic            i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [23:0]          o_sample_value,
    output logic                 o_in_range
);

    localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

    typedef struct packed {
        logic        in_range;
        logic        lv;
        logic        rv;
        logic [7:0]  frac;
        logic [15:0] mask;
    } t_ctl;

    logic signed [15:0] r_row [MAX_ROW];

    logic               en;
    logic               r_v1, r_v2, r_v3, r_v4;
    t_ctl               r_c1;
    logic               r_in2, r_in3, r_in4;
    logic [15:0]        r_mask2, r_mask3;
    logic signed [15:0] r_rd_l, r_rd_r;
    logic signed [25:0] r_pl, r_pr;
    logic signed [25:0] r_sum;
    logic signed [42:0] r_prod;
    logic               r_o_valid;
    logic [23:0]        r_o_value;
    logic               r_o_range;

    logic [8:0]         w_left;
    logic signed [25:0] m_left, m_right;
    logic signed [42:0] prod;
    logic signed [42:0] sh;
    logic [23:0]        sat;

    // whole pipe moves together unless the output beat is stuck
    assign en    = !r_o_valid || i_ready;
    assign o_pop = en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.is_load) begin
            r_row[AW'(i_entry.idx_lo)] <= i_entry.data;
        end
        if (en) begin
            r_rd_l <= r_row[AW'(i_entry.idx_lo)];
            r_rd_r <= r_row[AW'(i_entry.idx_hi)];
        end
    end

    assign w_left  = 9'd256 - {1'b0, r_c1.frac};
    assign m_left  = $signed({1'b0, w_left}) * r_rd_l;
    assign m_right = $signed({2'b00, r_c1.frac}) * r_rd_r;

    always_comb begin
        if (i_modulated) begin
            prod = 43'(r_sum) * 43'($signed({1'b0, r_mask3}));
        end else begin
            prod = 43'(r_sum) <<< 15;
        end
        sh = r_prod >>> 15;
        if (sh > 43'sd8388607) begin
            sat = 24'h7FFFFF;
        end else if (sh < -43'sd8388608) begin
            sat = 24'h800000;
        end else begin
            sat = sh[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_v1      <= o_pop && !i_entry.is_load;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_o_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1.in_range <= i_entry.in_range;
            r_c1.lv       <= i_entry.lv;
            r_c1.rv       <= i_entry.rv;
            r_c1.frac     <= i_entry.frac;
            r_c1.mask     <= i_entry.data;
            r_pl          <= r_c1.lv ? m_left : '0;
            r_pr          <= r_c1.rv ? m_right : '0;
            r_in2         <= r_c1.in_range;
            r_mask2       <= r_c1.mask;
            r_sum         <= r_pl + r_pr;
            r_in3         <= r_in2;
            r_mask3       <= r_mask2;
            r_prod        <= prod;
            r_in4         <= r_in3;
            r_o_value     <= sat;
            r_o_range     <= r_in4;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_sample_value = r_o_value;
    assign o_in_range     = r_o_range;

endmodule

`default_nettype wire

/* sv/deformable_1d_sampler.sv */
// channel   dir  width  handshake                    beat contents
// s_axis    in   80+1   s_axis_tvalid/s_axis_tready  load or sample request
// m_axis    out  24+1   m_axis_tvalid/m_axis_tready  interpolated sample
// apb       in   5/32   psel/penable/pwrite/pready   configuration registers
//
// one beat per cycle is taken while the four-entry queue has room; loads give no beat out
// a sample beat passes the front register, the queue and the back pipe; beats leave
// one per cycle while m_axis is not stalled, set by the two read ports of the row store
// reset clears control and registers only; the row store must be loaded before use
// a stalled m_axis freezes the back pipe; the queue then fills and drops s_axis_tready
`default_nettype none

module deformable_1d_sampler #(
    parameter int MAX_ROW = d1s_pkg::MAX_ROW_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // load_index, load_value, out_pos, tap, offset, weight, zero pad
    input  wire logic [79:0]                  s_axis_tdata,
    // action
    input  wire logic                         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // sample_value
    output logic [23:0]                       m_axis_tdata,
    // in_range
    output logic                              m_axis_tuser,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [d1s_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    d1s_pkg::t_cfg   r_cfg;
    d1s_pkg::t_entry f_entry;
    d1s_pkg::t_entry q_entry;
    logic [d1s_pkg::ENTRY_W-1:0] q_rdata;
    logic            f_push;
    logic            q_full;
    logic            q_empty;
    logic            b_pop;
    logic            wr_en;
    logic [2:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_width <= d1s_pkg::ROW_WIDTH_RST;
            r_cfg.stride    <= d1s_pkg::STRIDE_RST;
            r_cfg.padding   <= d1s_pkg::PADDING_RST;
            r_cfg.dilation  <= d1s_pkg::DILATION_RST;
            r_cfg.modulated <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                d1s_pkg::REG_ROW_WIDTH: r_cfg.row_width <= pwdata[10:0];
                d1s_pkg::REG_STRIDE:    r_cfg.stride    <= pwdata[4:0];
                d1s_pkg::REG_PADDING:   r_cfg.padding   <= pwdata[7:0];
                d1s_pkg::REG_DILATION:  r_cfg.dilation  <= pwdata[4:0];
                d1s_pkg::REG_MODULATED: r_cfg.modulated <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            d1s_pkg::REG_ROW_WIDTH: prdata = 32'(r_cfg.row_width);
            d1s_pkg::REG_STRIDE:    prdata = 32'(r_cfg.stride);
            d1s_pkg::REG_PADDING:   prdata = 32'(r_cfg.padding);
            d1s_pkg::REG_DILATION:  prdata = 32'(r_cfg.dilation);
            d1s_pkg::REG_MODULATED: prdata = 32'(r_cfg.modulated);
            default:                prdata = '0;
        endcase
    end

    d1s_front #(
        .MAX_ROW (MAX_ROW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_action      (s_axis_tuser),
        .i_load_index  (s_axis_tdata[9:0]),
        .i_load_value  (s_axis_tdata[25:10]),
        .i_out_pos     (s_axis_tdata[35:26]),
        .i_tap         (s_axis_tdata[39:36]),
        .i_offset      (s_axis_tdata[57:40]),
        .i_weight      (s_axis_tdata[73:58]),
        .o_push        (f_push),
        .o_entry       (f_entry),
        .i_full        (q_full)
    );

    d1s_queue #(
        .W     (d1s_pkg::ENTRY_W),
        .DEPTH (d1s_pkg::QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata (f_entry),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign q_entry = q_rdata;

    d1s_back #(
        .MAX_ROW (MAX_ROW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_modulated    (r_cfg.modulated),
        .i_entry        (q_entry),
        .i_empty        (q_empty),
        .o_pop          (b_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_sample_value (m_axis_tdata),
        .o_in_range     (m_axis_tuser)
    );

endmodule

`default_nettype wire
